@@ src/ist_pkg.sv @@
package ist_pkg;

  localparam int MAX_RANGES_DEF = 16;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } range_t;

  // true when a range ending at e lies below s with at least one value between
  function automatic logic apart(input logic [63:0] e, input logic [63:0] s);
    return (s > e) && ((s - e) > 64'd1);
  endfunction

endpackage

@@ src/ist_ifs.sv @@
interface ist_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] range_lo;
  logic [63:0] range_hi;
  modport source (output valid, req_type, range_lo, range_hi, input ready);
  modport sink   (input valid, req_type, range_lo, range_hi, output ready);
endinterface

interface ist_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] status;
  logic [4:0] ranges_held;
  modport source (output valid, hit, status, ranges_held, input ready);
  modport sink   (input valid, hit, status, ranges_held, output ready);
endinterface

@@ src/ist_range_mem.sv @@
module ist_range_mem #(
  parameter int MaxRanges = ist_pkg::MAX_RANGES_DEF,
  localparam int AW = $clog2(MaxRanges) + 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ist_pkg::range_t wdata,
  input  logic [AW-1:0]   raddr,
  output ist_pkg::range_t rdata
);

  // two banks, the bank bit is the address MSB
  ist_pkg::range_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/interval_set_table_unit.sv @@
// Channel  Dir  Words                     Payload
// req      in   one request               req_type, range_lo, range_hi
// rsp      out  one result per request    hit, status, ranges_held
//
// Steps: each stored range is read, then processed, one at a time through
// the single read port of the range memory; a remove that splits a range or
// an add that inserts ahead of one takes an extra write step for that entry.
// Reset clears the range count and the control state; the memory is not
// cleared, entries beyond the count are never used.
// A stalled result holds in the output register; a new request is taken
// meanwhile, and its own result waits until the register is free.
module interval_set_table_unit #(
  parameter int MaxRanges = ist_pkg::MAX_RANGES_DEF
) (
  input logic clk,
  input logic rst,
  ist_req_if.sink   req,
  ist_rsp_if.source rsp
);

  localparam int IW = $clog2(MaxRanges);
  localparam int AW = IW + 1;
  localparam int CW = $clog2(MaxRanges + 2);
  localparam logic [CW-1:0] MAXC = CW'(MaxRanges);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_PROC = 3'd2;
  localparam logic [2:0] S_WR2  = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]      state;
  logic [1:0]      op;
  logic [63:0]     lo, hi;        // request range, widened while merging
  logic            done;          // new range written (add)
  logic            touched;       // some stored range merged (add)
  logic            hit_acc;
  logic [1:0]      status;
  logic [CW-1:0]   i, k, n;
  logic            bank;          // bank holding the live table
  ist_pkg::range_t pend;          // second word of a two-write entry
  logic            out_load;      // result word moves into the output register

  ist_pkg::range_t rd_q;
  ist_pkg::range_t wdata;
  logic            want_wr;
  logic            we;
  logic [AW-1:0]   waddr, raddr;

  logic [63:0] s_c, e_c;
  logic        cov, left_c, right_c;

  assign s_c     = rd_q.lo;
  assign e_c     = rd_q.hi;
  assign cov     = !(e_c < lo || s_c > hi);
  assign left_c  = s_c < lo;
  assign right_c = e_c > hi;

  assign req.ready = (state == S_IDLE);
  assign raddr     = {bank, i[IW-1:0]};
  assign waddr     = {~bank, k[IW-1:0]};
  // drop writes beyond capacity; such a request ends as full anyway
  assign we        = want_wr && (k < MAXC);
  assign out_load  = (state == S_OUT) && (!rsp.valid || rsp.ready);

  // write word for the current step
  always_comb begin
    want_wr = 1'b0;
    wdata   = rd_q;
    unique case (state)
      S_PROC: begin
        if (op == ist_pkg::REQ_ADD) begin
          if (done || ist_pkg::apart(e_c, lo)) begin
            want_wr = 1'b1;
          end else if (ist_pkg::apart(hi, s_c)) begin
            want_wr = 1'b1;
            wdata   = '{lo: lo, hi: hi};
          end
        end else if (op == ist_pkg::REQ_REMOVE) begin
          if (!cov) begin
            want_wr = 1'b1;
          end else if (left_c) begin
            want_wr = 1'b1;
            wdata   = '{lo: s_c, hi: lo - 64'd1};
          end else if (right_c) begin
            want_wr = 1'b1;
            wdata   = '{lo: hi + 64'd1, hi: e_c};
          end
        end
      end
      S_WR2: begin
        want_wr = 1'b1;
        wdata   = pend;
      end
      S_END: begin
        if (op == ist_pkg::REQ_ADD && !done && (touched || n < MAXC)) begin
          want_wr = 1'b1;
          wdata   = '{lo: lo, hi: hi};
        end
      end
      default: ;
    endcase
  end

  ist_range_mem #(.MaxRanges(MaxRanges)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      bank      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op      <= req.req_type;
            lo      <= req.range_lo;
            hi      <= req.range_hi;
            done    <= 1'b0;
            touched <= 1'b0;
            hit_acc <= 1'b0;
            status  <= ist_pkg::ST_OK;
            i       <= '0;
            k       <= '0;
            if (req.req_type == ist_pkg::REQ_ADD || req.req_type == ist_pkg::REQ_REMOVE) begin
              if (req.range_lo > req.range_hi) begin
                status <= ist_pkg::ST_INVALID;
                state  <= S_OUT;
              end else begin
                state <= S_RD;
              end
            end else if (req.req_type == ist_pkg::REQ_QUERY) begin
              state <= S_RD;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_RD: begin
          state <= (i == n) ? S_END : S_PROC;
        end
        S_PROC: begin
          state <= S_RD;
          i     <= i + CW'(1);
          if (op == ist_pkg::REQ_ADD) begin
            if (done || ist_pkg::apart(e_c, lo)) begin
              k <= k + CW'(1);
            end else if (!ist_pkg::apart(hi, s_c)) begin
              // overlap or touch: widen and drop the stored range
              if (s_c < lo) lo <= s_c;
              if (e_c > hi) hi <= e_c;
              touched <= 1'b1;
            end else begin
              // place the new range, then copy this entry
              k     <= k + CW'(1);
              done  <= 1'b1;
              pend  <= rd_q;
              i     <= i;
              state <= S_WR2;
            end
          end else if (op == ist_pkg::REQ_REMOVE) begin
            if (!cov) begin
              k <= k + CW'(1);
            end else if (left_c && right_c) begin
              k     <= k + CW'(1);
              pend  <= '{lo: hi + 64'd1, hi: e_c};
              i     <= i;
              state <= S_WR2;
            end else if (left_c || right_c) begin
              k <= k + CW'(1);
            end
          end else begin
            if (s_c <= lo && lo <= e_c) hit_acc <= 1'b1;
          end
        end
        S_WR2: begin
          k     <= k + CW'(1);
          i     <= i + CW'(1);
          state <= S_RD;
        end
        S_END: begin
          state <= S_OUT;
          if (op == ist_pkg::REQ_ADD) begin
            // a range that touches nothing needs a free slot
            if (!touched && n >= MAXC) begin
              status <= ist_pkg::ST_FULL;
            end else begin
              n    <= done ? k : k + CW'(1);
              bank <= ~bank;
            end
          end else if (op == ist_pkg::REQ_REMOVE) begin
            if (k > MAXC) begin
              status <= ist_pkg::ST_FULL;
            end else begin
              n    <= k;
              bank <= ~bank;
            end
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            rsp.hit         <= hit_acc && (op == ist_pkg::REQ_QUERY);
            rsp.status      <= status;
            rsp.ranges_held <= 5'(n);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) n <= MAXC)
    else $error("range count above capacity");
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_OUT) |-> !we)
    else $error("memory write outside a scan");
  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && op == ist_pkg::REQ_QUERY) |-> !we)
    else $error("query wrote the table");
  a_out_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROC || state == S_WR2) |-> (k <= i + CW'(1)))
    else $error("write index ran ahead of read index");
`endif

endmodule
